### src/sparse_table_range_min_max_core_macros.svh
// Assertion helpers shared by the core
`ifndef SPARSE_TABLE_RANGE_MIN_MAX_CORE_MACROS_SVH
`define SPARSE_TABLE_RANGE_MIN_MAX_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define STRMM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define STRMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/strmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package strmm_pkg;

    localparam int IDX_W     = 11;
    localparam int CNT_W     = IDX_W + 1;
    localparam int LOG_W     = $clog2(CNT_W);
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_LEVEL_COUNT  = 11;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_NOT_BUILT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEMENT_COUNT = 1'b0,
        CFG_TAKE_MAXIMUM  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RD_QUERY_A = 2'd0,
        RD_QUERY_B = 2'd1,
        RD_BUILD_A = 2'd2,
        RD_BUILD_B = 2'd3
    } rd_sel_t;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_DISPATCH = 3'd1,
        S_QRD_A    = 3'd2,
        S_QRD_B    = 3'd3,
        S_QCMB     = 3'd4,
        S_BRD_A    = 3'd5,
        S_BRD_B    = 3'd6,
        S_BWR      = 3'd7
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    wr_load;
        logic    wr_build;
        rd_sel_t rd_sel;
        logic    hold_a;
        logic    build_init;
        logic    next_pos;
        logic    next_level;
        logic    set_built;
        logic    res_load;
        status_t res_status;
        logic    res_from_mem;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       load_ok;
        logic       built;
        logic       query_ok;
        logic       build_empty;
        logic       last_pos;
        logic       last_level;
    } dp_stat_t;

    function automatic logic signed [VAL_W-1:0] combine(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic                    take_max
    );
        logic a_less;
        a_less = a < b;
        if (take_max)
            return a_less ? b : a;
        return a_less ? a : b;
    endfunction

    function automatic logic [LOG_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
        logic [LOG_W-1:0] k;
        k = '0;
        for (int i = 1; i < CNT_W; i++)
        begin
            if (v[i])
                k = LOG_W'(i);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### src/strmm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module strmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/strmm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module strmm_ctrl
    import strmm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (cmd_t'(stat.command))
                    CMD_BUILD:
                    begin
                        if (!stat.build_empty)
                            state_next = S_BRD_A;
                    end
                    CMD_QUERY:
                    begin
                        if (stat.built && stat.query_ok)
                            state_next = S_QRD_A;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_QRD_A: state_next = S_QRD_B;
            S_QRD_B: state_next = S_QCMB;
            S_QCMB:  state_next = S_IDLE;
            S_BRD_A: state_next = S_BRD_B;
            S_BRD_B: state_next = S_BWR;
            S_BWR:
            begin
                if (stat.last_pos && stat.last_level)
                    state_next = S_IDLE;
                else
                    state_next = S_BRD_A;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE: ctl.capture = start;
            S_DISPATCH:
            begin
                case (cmd_t'(stat.command))
                    CMD_LOAD:
                    begin
                        ctl.wr_load    = stat.load_ok;
                        ctl.res_load   = 1'b1;
                        ctl.res_status = stat.load_ok ? ST_OK : ST_BAD_RANGE;
                    end
                    CMD_BUILD:
                    begin
                        ctl.build_init = 1'b1;
                        if (stat.build_empty)
                        begin
                            ctl.set_built  = 1'b1;
                            ctl.res_load   = 1'b1;
                            ctl.res_status = ST_OK;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (!stat.built)
                        begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = ST_NOT_BUILT;
                        end
                        else if (!stat.query_ok)
                        begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = ST_BAD_RANGE;
                        end
                    end
                    default:
                    begin
                        ctl.res_load   = 1'b1;
                        ctl.res_status = ST_BAD_RANGE;
                    end
                endcase
            end
            S_QRD_A: ctl.rd_sel = RD_QUERY_A;
            S_QRD_B:
            begin
                ctl.rd_sel = RD_QUERY_B;
                ctl.hold_a = 1'b1;
            end
            S_QCMB:
            begin
                ctl.res_load     = 1'b1;
                ctl.res_status   = ST_OK;
                ctl.res_from_mem = 1'b1;
            end
            S_BRD_A: ctl.rd_sel = RD_BUILD_A;
            S_BRD_B:
            begin
                ctl.rd_sel = RD_BUILD_B;
                ctl.hold_a = 1'b1;
            end
            S_BWR:
            begin
                ctl.wr_build = 1'b1;
                if (!stat.last_pos)
                    ctl.next_pos = 1'b1;
                else if (!stat.last_level)
                    ctl.next_level = 1'b1;
                else
                begin
                    ctl.set_built  = 1'b1;
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_OK;
                end
            end
            default: ctl = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/strmm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module strmm_datapath
    import strmm_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int LEVEL_COUNT  = DEF_LEVEL_COUNT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic [1:0]              command,
    input  wire logic [IDX_W-1:0]        left_index,
    input  wire logic [IDX_W-1:0]        right_index,
    input  wire logic signed [VAL_W-1:0] element_value,
    input  wire ctl_cmd_t                ctl,
    output dp_stat_t                     stat,
    output logic                         done,
    output logic signed [VAL_W-1:0]      answer_value,
    output logic [1:0]                   status
);

    localparam int POS_W     = $clog2(MAX_ELEMENTS);
    localparam int LVL_W     = $clog2(LEVEL_COUNT);
    localparam int ADDR_W    = LVL_W + POS_W;
    localparam int RAM_DEPTH = LEVEL_COUNT * (2 ** POS_W);
    localparam int LVL_CAP   = (2 ** LEVEL_COUNT) - 1;
    localparam int CAP       = (MAX_ELEMENTS < LVL_CAP) ? MAX_ELEMENTS : LVL_CAP;

    // configuration and table state
    logic [CFG_W-1:0] count_reg;
    logic [CFG_W-1:0] count_next;
    logic             max_reg;
    logic             max_next;
    logic             built_reg;
    logic             built_next;

    // captured word
    logic [1:0]              cmd_reg;
    logic [IDX_W-1:0]        left_reg;
    logic [IDX_W-1:0]        right_reg;
    logic signed [VAL_W-1:0] value_reg;

    // query plan and build walk
    logic [LOG_W-1:0]        kq_reg;
    logic [CNT_W-1:0]        sec_reg;
    logic [LVL_W-1:0]        k_reg;
    logic [LVL_W-1:0]        k_next;
    logic [CNT_W-1:0]        span_reg;
    logic [CNT_W-1:0]        span_next;
    logic [CNT_W-1:0]        j_reg;
    logic [CNT_W-1:0]        j_next;
    logic signed [VAL_W-1:0] a_reg;

    // result register
    logic                    done_reg;
    logic                    done_next;
    logic signed [VAL_W-1:0] answer_reg;
    logic signed [VAL_W-1:0] answer_next;
    status_t                 status_reg;
    status_t                 status_next;

    logic [CNT_W-1:0]        n_eff;
    logic [CNT_W-1:0]        q_len;
    logic [LOG_W-1:0]        kq_next;
    logic [CNT_W-1:0]        sec_next;
    logic signed [VAL_W-1:0] combined;
    logic [LVL_W-1:0]        rd_lvl;
    logic [POS_W-1:0]        rd_pos;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic [VAL_W-1:0]        ram_rdata;

    // effective element count, saturated to what the levels and store can hold
    always_comb
    begin
        n_eff = {1'b0, count_reg};
        if (32'(count_reg) > CAP)
            n_eff = CNT_W'(CAP);
    end

    assign q_len    = {1'b0, right_reg} - {1'b0, left_reg} + CNT_W'(1);
    assign kq_next  = floor_log2(q_len);
    assign sec_next = {1'b0, right_reg} - (CNT_W'(1) << kq_next);
    assign combined = combine(a_reg, $signed(ram_rdata), max_reg);

    always_comb
    begin
        stat.command     = cmd_reg;
        stat.load_ok     = (left_reg != '0) && (32'(left_reg) <= MAX_ELEMENTS);
        stat.built       = built_reg;
        stat.query_ok    = (left_reg != '0) && (right_reg >= left_reg)
                           && ({1'b0, right_reg} <= n_eff);
        stat.build_empty = (n_eff < CNT_W'(2));
        stat.last_pos    = ((j_reg + span_reg) == n_eff);
        stat.last_level  = ((span_reg << 1) > n_eff);
    end

    always_comb
    begin
        case (ctl.rd_sel)
            RD_QUERY_A:
            begin
                rd_lvl = LVL_W'(kq_reg);
                rd_pos = POS_W'(left_reg - IDX_W'(1));
            end
            RD_QUERY_B:
            begin
                rd_lvl = LVL_W'(kq_reg);
                rd_pos = POS_W'(sec_reg);
            end
            RD_BUILD_A:
            begin
                rd_lvl = k_reg - LVL_W'(1);
                rd_pos = POS_W'(j_reg);
            end
            RD_BUILD_B:
            begin
                rd_lvl = k_reg - LVL_W'(1);
                rd_pos = POS_W'(j_reg + (span_reg >> 1));
            end
            default:
            begin
                rd_lvl = '0;
                rd_pos = '0;
            end
        endcase
    end

    always_comb
    begin
        ram_we = ctl.wr_load || ctl.wr_build;
        if (ctl.wr_load)
        begin
            ram_waddr = {LVL_W'(0), POS_W'(left_reg - IDX_W'(1))};
            ram_wdata = value_reg;
        end
        else
        begin
            ram_waddr = {k_reg, POS_W'(j_reg)};
            ram_wdata = combined;
        end
    end

    strmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_level_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr ({rd_lvl, rd_pos}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next  = count_reg;
        max_next    = max_reg;
        built_next  = built_reg;
        k_next      = k_reg;
        span_next   = span_reg;
        j_next      = j_reg;
        done_next   = ctl.res_load;
        answer_next = answer_reg;
        status_next = status_reg;

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ELEMENT_COUNT: count_next = cfg_data;
                CFG_TAKE_MAXIMUM:  max_next   = cfg_data[0];
                default:           count_next = count_reg;
            endcase
        end

        if (ctl.set_built)
            built_next = 1'b1;
        // any new element or register write makes the table stale
        if (cfg_we || ctl.wr_load)
            built_next = 1'b0;

        if (ctl.build_init)
        begin
            k_next    = LVL_W'(1);
            span_next = CNT_W'(2);
            j_next    = '0;
        end
        else if (ctl.next_level)
        begin
            k_next    = k_reg + LVL_W'(1);
            span_next = span_reg << 1;
            j_next    = '0;
        end
        else if (ctl.next_pos)
        begin
            j_next = j_reg + CNT_W'(1);
        end

        if (ctl.res_load)
        begin
            answer_next = ctl.res_from_mem ? combined : '0;
            status_next = ctl.res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CFG_W'(1);
            max_reg   <= 1'b0;
            built_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            max_reg   <= max_next;
            built_reg <= built_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= command;
            left_reg  <= left_index;
            right_reg <= right_index;
            value_reg <= element_value;
        end
        if (ctl.hold_a)
            a_reg <= $signed(ram_rdata);
        // plan follows the captured word; only read once the query is under way
        kq_reg     <= kq_next;
        sec_reg    <= sec_next;
        k_reg      <= k_next;
        span_reg   <= span_next;
        j_reg      <= j_next;
        answer_reg <= answer_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign answer_value = answer_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

### src/sparse_table_range_min_max_core.sv
// Sparse table for range minimum / maximum queries.
// Command channel: a word (command, left_index, right_index, element_value) is
// taken at a clock edge with start high and busy low. Commands: load one element
// at position left_index, build all levels, or query the range left..right.
// Result channel: done is high for exactly one cycle with answer_value and
// status; the receiver cannot hold it off, so it must take the word then.
// Configuration: cfg_we with cfg_index 0 writes element_count, index 1 writes
// take_maximum; write only while the block is idle. Any write marks the table
// stale, as does any load that lands.
// Sequence, from the accepting edge to the edge at which done is taken:
//   load, flagged query or unknown command: dispatch, then the result register;
//   query: dispatch, two reads of the single-read-port level store, combine;
//   build: dispatch, then two reads and one write of the level store for each
//   entry computed over all levels; the next word is accepted when done is taken.
// Reset clears the controller, the registers (count 1, minimum mode) and the
// built flag; the level store is not cleared, so loads must precede a build.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_table_range_min_max_core_macros.svh"

module sparse_table_range_min_max_core
    import strmm_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int LEVEL_COUNT  = DEF_LEVEL_COUNT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              command,
    input  wire logic [IDX_W-1:0]        left_index,
    input  wire logic [IDX_W-1:0]        right_index,
    input  wire logic signed [VAL_W-1:0] element_value,
    output logic                         done,
    output logic signed [VAL_W-1:0]      answer_value,
    output logic [1:0]                   status
);

    ctl_cmd_t ctl;
    dp_stat_t stat;

    strmm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    strmm_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVEL_COUNT  (LEVEL_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .left_index    (left_index),
        .right_index   (right_index),
        .element_value (element_value),
        .ctl           (ctl),
        .stat          (stat),
        .done          (done),
        .answer_value  (answer_value),
        .status        (status)
    );

    `STRMM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
    `STRMM_ASSERT_SAME(a_finish_done, clk, rst_n, $fell(busy), done, "item finished without a result")
    `STRMM_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe held for two cycles")
    `STRMM_ASSERT_SAME(a_flag_zero, clk, rst_n, done && (status != ST_OK), answer_value == '0, "flagged result carries a value")

endmodule

`default_nettype wire
